// ===== rtl/core/bitcrush_pkg.sv =====
package bitcrush_pkg;

	// Sample format: two's complement, one integer bit (the sign).
	localparam int SAMPLE_WIDTH = 24;
	localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;

	// Phase accumulator and mix are unsigned fractions; one is 1 << FRAC_BITS.
	localparam int PHASE_FRAC_BITS = 16;
	localparam int MIX_FRAC_BITS = 16;
	localparam int STEP_WIDTH = PHASE_FRAC_BITS + 1;
	localparam int MIX_WIDTH = MIX_FRAC_BITS + 1;

	localparam int CRUSH_WIDTH = 4;
	localparam int CFG_DATA_WIDTH = 17;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [STEP_WIDTH-1:0] phase_step_t;
	typedef logic [MIX_WIDTH-1:0] mix_t;
	typedef logic [CRUSH_WIDTH-1:0] crush_t;
	typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_LOFI_ENABLE     = 2'd0,
		REG_CRUSH_BITS      = 2'd1,
		REG_MIX_AMOUNT      = 2'd2,
		REG_PHASE_INCREMENT = 2'd3
	} cfg_reg_t;

endpackage

// ===== rtl/core/bitcrush_ifs.sv =====
interface bitcrush_in_if;
	logic valid;
	logic ready;
	bitcrush_pkg::sample_t left_in;
	bitcrush_pkg::sample_t right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface bitcrush_out_if;
	logic valid;
	logic ready;
	bitcrush_pkg::sample_t left_out;
	bitcrush_pkg::sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/core/bitcrush_sample_rate_reducer_core.sv =====
// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------
// dry      sink       left_in, right_in: one stereo pair, signed Q1.23
// wet      source     left_out, right_out: one processed pair, signed Q1.23
// cfg      write      cfg_wr_en, cfg_index, cfg_data: register writes
//
// One beat is accepted per cycle while wet takes results, and each beat gives
// one result beat: the input register takes the pair to process together
// with the hold and phase update, then the result register takes the
// quantised and blended pair. Each register has its own ready, so dry keeps
// accepting while a finished result waits on wet until both registers are full.
// Reset (arst_n low) clears the valids, phase and hold registers and returns
// the configuration registers to their default values.
module bitcrush_sample_rate_reducer_core (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_wr_en,
	input  logic [bitcrush_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  bitcrush_pkg::cfg_data_t                      cfg_data,
	bitcrush_in_if.sink                                  dry,
	bitcrush_out_if.source                               wet
);
	import bitcrush_pkg::*;

	localparam int SH_WIDTH = $clog2(SAMPLE_WIDTH);
	localparam int EXT_WIDTH = SAMPLE_WIDTH + 1;
	localparam int PROD_WIDTH = SAMPLE_FRAC + MIX_WIDTH + 1;

	typedef struct packed {
		logic                   neg;
		logic [SAMPLE_FRAC-1:0] mag;
	} diff_t;

	// Rounds x to the given number of fractional bits, half away from zero,
	// saturating a positive value that reaches +1.0, and returns the
	// difference between the rounded value and x as sign and magnitude.
	function automatic diff_t crush_diff(input sample_t x, input crush_t bits);
		logic [SH_WIDTH-1:0]          sh;
		logic signed [EXT_WIDTH-1:0]  xe;
		logic [EXT_WIDTH-1:0]         mag;
		logic [EXT_WIDTH-1:0]         half;
		logic [EXT_WIDTH-1:0]         lo_mask;
		logic [EXT_WIDTH-1:0]         q;
		logic signed [EXT_WIDTH-1:0]  r;
		logic signed [EXT_WIDTH-1:0]  d;
		diff_t                        res;
		sh = SH_WIDTH'(SAMPLE_FRAC) - SH_WIDTH'(bits);
		xe = EXT_WIDTH'(x);
		mag = xe[EXT_WIDTH-1] ? EXT_WIDTH'(-xe) : EXT_WIDTH'(xe);
		half = EXT_WIDTH'(1) << (sh - SH_WIDTH'(1));
		lo_mask = (EXT_WIDTH'(1) << sh) - EXT_WIDTH'(1);
		q = (mag + half) & ~lo_mask;
		r = xe[EXT_WIDTH-1] ? -$signed(q) : $signed(q);
		if (r > $signed(EXT_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}))) begin
			r = $signed(EXT_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
		end
		d = r - xe;
		// Keeping at least as many fractional bits as the sample has leaves it untouched.
		if (32'(bits) >= SAMPLE_FRAC) begin
			d = '0;
		end
		res.neg = d[EXT_WIDTH-1];
		res.mag = d[EXT_WIDTH-1] ? SAMPLE_FRAC'(-d) : SAMPLE_FRAC'(d);
		return res;
	endfunction

	// Configuration registers.
	logic        lofi_enable_q;
	crush_t      crush_bits_q;
	mix_t        mix_amount_q;
	phase_step_t phase_increment_q;

	// Processing state.
	logic [PHASE_FRAC_BITS-1:0] phase_q;
	sample_t                    held_left_q;
	sample_t                    held_right_q;

	// Input and result registers.
	logic    valid_s1, valid_s2;
	logic    ready_s1, ready_s2;
	logic    bypass_s1;
	sample_t left_s1, right_s1;
	sample_t left_s2, right_s2;

	logic        accept;
	phase_step_t step;
	phase_step_t phase_sum;
	logic        wrap;
	sample_t     pick_left, pick_right;
	mix_t        mix;
	diff_t       diff_left, diff_right;
	logic [PROD_WIDTH-1:0] prod_left, prod_right;
	sample_t     adj_left, adj_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lofi_enable_q <= 1'b0;
			crush_bits_q <= CRUSH_WIDTH'(14);
			mix_amount_q <= '0;
			phase_increment_q <= STEP_WIDTH'(1) << PHASE_FRAC_BITS;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOFI_ENABLE:     lofi_enable_q <= cfg_data[0];
				REG_CRUSH_BITS:      crush_bits_q <= cfg_data[CRUSH_WIDTH-1:0];
				REG_MIX_AMOUNT:      mix_amount_q <= cfg_data[MIX_WIDTH-1:0];
				REG_PHASE_INCREMENT: phase_increment_q <= cfg_data[STEP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Each register moves on when it is empty or the one after it takes its beat.
	assign ready_s2 = !valid_s2 || wet.ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign dry.ready = ready_s1;
	assign accept = dry.valid && ready_s1;

	// Phase step: an increment above one acts as one, so the accumulator is
	// always below one after the subtraction and fits its fractional bits.
	assign step = phase_increment_q[PHASE_FRAC_BITS] ? (STEP_WIDTH'(1) << PHASE_FRAC_BITS)
		: phase_increment_q;
	assign phase_sum = STEP_WIDTH'(phase_q) + step;
	assign wrap = phase_sum[PHASE_FRAC_BITS];

	// A pass-through beat and a beat that wraps the phase both use the input
	// pair; otherwise the pair captured earlier is processed again.
	always_comb begin
		if (!lofi_enable_q || wrap) begin
			pick_left = dry.left_in;
			pick_right = dry.right_in;
		end else begin
			pick_left = held_left_q;
			pick_right = held_right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held_left_q <= '0;
			held_right_q <= '0;
		end else if (accept && lofi_enable_q) begin
			phase_q <= phase_sum[PHASE_FRAC_BITS-1:0];
			if (wrap) begin
				held_left_q <= dry.left_in;
				held_right_q <= dry.right_in;
			end
		end
	end

	// Input register: sample to process.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1 <= pick_left;
			right_s1 <= pick_right;
			bypass_s1 <= !lofi_enable_q;
		end
	end

	// Quantise and take the distance to the crushed value. A pass-through
	// beat gets a zero distance, so the blend leaves it as it is.
	always_comb begin
		diff_left = crush_diff(left_s1, crush_bits_q);
		diff_right = crush_diff(right_s1, crush_bits_q);
		if (bypass_s1) begin
			diff_left = '0;
			diff_right = '0;
		end
	end

	// Scale the distance by the mix, rounding half away from zero, and add it
	// back. The result lies between the sample and its crushed value, so it
	// always fits the sample width.
	assign mix = mix_amount_q[MIX_FRAC_BITS] ? (MIX_WIDTH'(1) << MIX_FRAC_BITS) : mix_amount_q;
	assign prod_left = PROD_WIDTH'(diff_left.mag) * PROD_WIDTH'(mix)
		+ (PROD_WIDTH'(1) << (MIX_FRAC_BITS - 1));
	assign prod_right = PROD_WIDTH'(diff_right.mag) * PROD_WIDTH'(mix)
		+ (PROD_WIDTH'(1) << (MIX_FRAC_BITS - 1));
	assign adj_left = SAMPLE_WIDTH'(prod_left >> MIX_FRAC_BITS);
	assign adj_right = SAMPLE_WIDTH'(prod_right >> MIX_FRAC_BITS);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			left_s2 <= diff_left.neg ? left_s1 - adj_left : left_s1 + adj_left;
			right_s2 <= diff_right.neg ? right_s1 - adj_right : right_s1 + adj_right;
		end
	end

	assign wet.valid = valid_s2;
	assign wet.left_out = left_s2;
	assign wet.right_out = right_s2;

endmodule
